FILE: rtl/core/rte_pkg.sv
package rte_pkg;

  localparam int unsigned LineW  = 12;
  localparam int unsigned XlenW  = 32;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned PrivW  = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_MIE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIDELEG = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MEDELEG = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MTVEC   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STVEC   = 3'd4;

  localparam logic [PrivW-1:0] PRIV_U = 2'd0;
  localparam logic [PrivW-1:0] PRIV_S = 2'd1;
  localparam logic [PrivW-1:0] PRIV_M = 2'd3;

  localparam int unsigned SIE_POS  = 1;
  localparam int unsigned MIE_POS  = 3;
  localparam int unsigned SPIE_POS = 5;
  localparam int unsigned MPIE_POS = 7;
  localparam int unsigned SPP_POS  = 8;
  localparam int unsigned MPP_LO   = 11;
  localparam int unsigned MPP_HI   = 12;

  localparam logic [CodeW-1:0] IRQ_MEI = 4'd11;
  localparam logic [CodeW-1:0] IRQ_MSI = 4'd3;
  localparam logic [CodeW-1:0] IRQ_MTI = 4'd7;
  localparam logic [CodeW-1:0] IRQ_SEI = 4'd9;
  localparam logic [CodeW-1:0] IRQ_SSI = 4'd1;
  localparam logic [CodeW-1:0] IRQ_STI = 4'd5;
  localparam logic [CodeW-1:0] IRQ_NONE = 4'd0;

  localparam logic [1:0] VEC_MODE_VECTORED = 2'd1;

  typedef struct packed {
    logic [LineW-1:0] pending_lines;
    logic [XlenW-1:0] current_pc;
    logic             trap_request;
    logic [XlenW-1:0] trap_cause;
    logic [XlenW-1:0] trap_value;
  } in_item_t;

  typedef struct packed {
    logic             interrupt_found;
    logic [CodeW-1:0] interrupt_code;
    logic             trap_taken;
    logic             to_supervisor;
    logic [XlenW-1:0] target_pc;
    logic [PrivW-1:0] new_privilege;
    logic [XlenW-1:0] status_after;
    logic [XlenW-1:0] saved_epc;
  } out_item_t;

  typedef struct packed {
    logic [LineW-1:0] mie;
    logic [LineW-1:0] mideleg;
    logic [XlenW-1:0] medeleg;
    logic [XlenW-1:0] mtvec;
    logic [XlenW-1:0] stvec;
  } cfg_t;

  typedef struct packed {
    logic [PrivW-1:0] priv;
    logic [XlenW-1:0] status;
  } state_t;

  typedef struct packed {
    logic             found;
    logic [CodeW-1:0] code;
  } irq_t;

  typedef struct packed {
    logic             trap_taken;
    logic             to_supervisor;
    logic [XlenW-1:0] target_pc;
    logic [PrivW-1:0] new_privilege;
    logic [XlenW-1:0] status_after;
    logic [XlenW-1:0] saved_epc;
  } trap_res_t;

endpackage

FILE: rtl/core/rte_if.sv
interface rte_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] pending_lines;
  logic [31:0] current_pc;
  logic        trap_request;
  logic [31:0] trap_cause;
  logic [31:0] trap_value;

  modport source (output valid, pending_lines, current_pc, trap_request, trap_cause,
                  trap_value, input ready);
  modport sink (input valid, pending_lines, current_pc, trap_request, trap_cause,
                trap_value, output ready);
endinterface

interface rte_out_if;
  logic        valid;
  logic        ready;
  logic        interrupt_found;
  logic [3:0]  interrupt_code;
  logic        trap_taken;
  logic        to_supervisor;
  logic [31:0] target_pc;
  logic [1:0]  new_privilege;
  logic [31:0] status_after;
  logic [31:0] saved_epc;

  modport source (output valid, interrupt_found, interrupt_code, trap_taken, to_supervisor,
                  target_pc, new_privilege, status_after, saved_epc, input ready);
  modport sink (input valid, interrupt_found, interrupt_code, trap_taken, to_supervisor,
                target_pc, new_privilege, status_after, saved_epc, output ready);
endinterface

interface rte_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/rte_cfg_regs.sv
module rte_cfg_regs import rte_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_idx_i,
  input  logic [XlenW-1:0]   wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        CFG_MIE:     cfg_d.mie     = wr_data_i[LineW-1:0];
        CFG_MIDELEG: cfg_d.mideleg = wr_data_i[LineW-1:0];
        CFG_MEDELEG: cfg_d.medeleg = wr_data_i;
        CFG_MTVEC:   cfg_d.mtvec   = wr_data_i;
        CFG_STVEC:   cfg_d.stvec   = wr_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/rte_irq_arb.sv
module rte_irq_arb import rte_pkg::*; (
  input  logic [LineW-1:0] lines_i,
  input  cfg_t             cfg_i,
  input  state_t           state_i,
  output irq_t             irq_o
);

  logic [LineW-1:0] pend;
  logic [LineW-1:0] active;
  logic             m_en;
  logic             s_en;

  always_comb begin
    pend   = lines_i & cfg_i.mie;
    m_en   = (state_i.priv != PRIV_M) || state_i.status[MIE_POS];
    s_en   = (state_i.priv == PRIV_U) ||
             ((state_i.priv == PRIV_S) && state_i.status[SIE_POS]);
    active = ((m_en ? pend & ~cfg_i.mideleg : '0) | (s_en ? pend & cfg_i.mideleg : '0));
  end

  always_comb begin
    irq_o.found = 1'b1;
    priority if (active[IRQ_MEI]) irq_o.code = IRQ_MEI;
    else if (active[IRQ_MSI])     irq_o.code = IRQ_MSI;
    else if (active[IRQ_MTI])     irq_o.code = IRQ_MTI;
    else if (active[IRQ_SEI])     irq_o.code = IRQ_SEI;
    else if (active[IRQ_SSI])     irq_o.code = IRQ_SSI;
    else if (active[IRQ_STI])     irq_o.code = IRQ_STI;
    else begin
      irq_o.found = 1'b0;
      irq_o.code  = IRQ_NONE;
    end
  end

endmodule

FILE: rtl/core/rte_trap_ctrl.sv
module rte_trap_ctrl import rte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      commit_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output state_t    state_o,
  output trap_res_t res_o
);

  logic [PrivW-1:0] priv_q, priv_d;
  logic [XlenW-1:0] status_q, status_d;

  logic             is_irq;
  logic [XlenW-2:0] code;
  logic             code_small;
  logic [XlenW-1:0] irq_deleg;
  logic             deleg_bit;
  logic             deleg;
  logic [XlenW-1:0] vec;
  logic [XlenW-1:0] base;
  logic [XlenW-1:0] target;

  always_comb begin
    is_irq     = item_i.trap_cause[XlenW-1];
    code       = item_i.trap_cause[XlenW-2:0];
    code_small = (code[XlenW-2:5] == '0);
    irq_deleg  = {{(XlenW-LineW){1'b0}}, cfg_i.mideleg};
    deleg_bit  = is_irq ? irq_deleg[code[4:0]] : cfg_i.medeleg[code[4:0]];
    deleg      = item_i.trap_request && (priv_q == PRIV_U || priv_q == PRIV_S) &&
                 code_small && deleg_bit;

    vec  = deleg ? cfg_i.stvec : cfg_i.mtvec;
    base = {vec[XlenW-1:2], 2'b00};
    if ((vec[1:0] == VEC_MODE_VECTORED) && is_irq) begin
      target = base + {code[XlenW-3:0], 2'b00};
    end else begin
      target = base;
    end

    priv_d   = priv_q;
    status_d = status_q;
    if (item_i.trap_request) begin
      if (deleg) begin
        status_d[SPIE_POS] = status_q[SIE_POS];
        status_d[SIE_POS]  = 1'b0;
        status_d[SPP_POS]  = (priv_q == PRIV_S);
        priv_d             = PRIV_S;
      end else begin
        status_d[MPIE_POS]      = status_q[MIE_POS];
        status_d[MIE_POS]       = 1'b0;
        status_d[MPP_HI:MPP_LO] = priv_q;
        priv_d                  = PRIV_M;
      end
    end

    res_o.trap_taken    = item_i.trap_request;
    res_o.to_supervisor = deleg;
    res_o.target_pc     = item_i.trap_request ? target : '0;
    res_o.new_privilege = priv_d;
    res_o.status_after  = status_d;
    res_o.saved_epc     = item_i.trap_request ? {item_i.current_pc[XlenW-1:1], 1'b0} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      priv_q   <= PRIV_M;
      status_q <= '0;
    end else if (commit_i) begin
      priv_q   <= priv_d;
      status_q <= status_d;
    end
  end

  assign state_o.priv   = priv_q;
  assign state_o.status = status_q;

endmodule

FILE: rtl/core/rv32_trap_entry_unit_core.sv
// path: an accepted item passes through the input register, then the result register
// throughput: one item per cycle while the output is not stalled; privilege and
// mstatus update as the item leaves the input register, so the next item sees them
// reset: privilege machine, mstatus zero, all config registers zero, both stages empty
module rv32_trap_entry_unit_core import rte_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rte_in_if.sink    in_i,
  rte_out_if.source out_o,
  rte_cfg_if.sink   cfg_i
);

  cfg_t      cfg;
  state_t    state;
  irq_t      irq;
  trap_res_t res;

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  logic      in_acc;
  logic      out_free;
  logic      advance;

  assign cfg_i.ready = 1'b1;

  rte_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  rte_irq_arb u_irq (
    .lines_i (s1_q.pending_lines),
    .cfg_i   (cfg),
    .state_i (state),
    .irq_o   (irq)
  );

  rte_trap_ctrl u_trap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (advance),
    .item_i   (s1_q),
    .cfg_i    (cfg),
    .state_o  (state),
    .res_o    (res)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.pending_lines <= in_i.pending_lines;
      s1_q.current_pc    <= in_i.current_pc;
      s1_q.trap_request  <= in_i.trap_request;
      s1_q.trap_cause    <= in_i.trap_cause;
      s1_q.trap_value    <= in_i.trap_value;
    end
    if (advance) begin
      out_q.interrupt_found <= irq.found;
      out_q.interrupt_code  <= irq.code;
      out_q.trap_taken      <= res.trap_taken;
      out_q.to_supervisor   <= res.to_supervisor;
      out_q.target_pc       <= res.target_pc;
      out_q.new_privilege   <= res.new_privilege;
      out_q.status_after    <= res.status_after;
      out_q.saved_epc       <= res.saved_epc;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.interrupt_found = out_q.interrupt_found;
  assign out_o.interrupt_code  = out_q.interrupt_code;
  assign out_o.trap_taken      = out_q.trap_taken;
  assign out_o.to_supervisor   = out_q.to_supervisor;
  assign out_o.target_pc       = out_q.target_pc;
  assign out_o.new_privilege   = out_q.new_privilege;
  assign out_o.status_after    = out_q.status_after;
  assign out_o.saved_epc       = out_q.saved_epc;

`ifndef SYNTHESIS
  a_priv_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.priv != 2'd2)
    else $error("reserved privilege reached");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("item stuck in input register");

  a_no_trap_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.trap_taken) |->
      (!out_q.to_supervisor && out_q.saved_epc == '0 && out_q.target_pc == '0))
    else $error("trap fields set without a trap");

  a_deleg_priv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.to_supervisor) |-> (out_q.new_privilege == PRIV_S))
    else $error("delegated trap not in supervisor mode");
`endif

endmodule
